[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // Queue sizing (depth must be a power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Input action codes
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_ADDR  = 3'd3;
    localparam logic [2:0] ACT_WRITE = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    // Reset value of the tick-per-microsecond register
    localparam logic [9:0] TICKS_PER_US_RESET = 10'd72;

    // Classified item kinds
    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_FRAME = 3'd3,
        KIND_READ  = 3'd4,
        KIND_NONE  = 3'd5
    } i2cm_kind_t;

    // Classified item passed from front to back
    typedef struct packed {
        i2cm_kind_t  kind;
        logic        sda;       // sampled SDA (ticks)
        logic [7:0]  shift;     // first byte of a frame
        logic [7:0]  low_byte;  // low address byte of a 10-bit address
        logic        pend;      // a second frame follows if acked
        logic        rw_short;  // R/W bit of a 7-bit address uses short halves
    } i2cm_item_t;

    // Result item
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic        ack;
        logic [7:0]  rdata;
    } i2cm_result_t;

    // Bus engine phases
    typedef enum logic [15:0] {
        PH_IDLE  = 16'h0001,
        PH_S1    = 16'h0002,
        PH_S2    = 16'h0004,
        PH_S3    = 16'h0008,
        PH_T1    = 16'h0010,
        PH_T2    = 16'h0020,
        PH_T3    = 16'h0040,
        PH_BSET  = 16'h0080,
        PH_BHIGH = 16'h0100,
        PH_BLOW  = 16'h0200,
        PH_KREL  = 16'h0400,
        PH_KHIGH = 16'h0800,
        PH_KHOLD = 16'h1000,
        PH_KLOW  = 16'h2000,
        PH_RHIGH = 16'h4000,
        PH_RLOW  = 16'h8000
    } i2cm_phase_t;

endpackage

`default_nettype wire

[rtl/i2cm_front.sv]
// Front end: accepts input items, classifies them and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  action,
    input  wire logic        sda_in,
    input  wire logic [9:0]  address,
    input  wire logic        ten_bit_mode,
    input  wire logic        read_not_write,
    input  wire logic [7:0]  write_data,
    output i2cm_item_t       mid_item,
    output logic             mid_valid,
    input  wire logic        mid_pop
);

    i2cm_item_t           q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    i2cm_item_t           cls;
    logic                 in_acc;
    logic                 q_pop;

    // Classify the incoming item
    always_comb
    begin
        cls          = '0;
        cls.kind     = KIND_NONE;
        cls.sda      = sda_in;
        case (action)
            ACT_TICK:  cls.kind = KIND_TICK;
            ACT_START: cls.kind = KIND_START;
            ACT_STOP:  cls.kind = KIND_STOP;
            ACT_ADDR:
            begin
                cls.kind = KIND_FRAME;
                if (ten_bit_mode)
                begin
                    cls.shift    = {5'b11110, address[9:8], read_not_write};
                    cls.low_byte = address[7:0];
                    cls.pend     = 1'b1;
                    cls.rw_short = 1'b0;
                end
                else
                begin
                    cls.shift    = {address[6:0], read_not_write};
                    cls.pend     = 1'b0;
                    cls.rw_short = 1'b1;
                end
            end
            ACT_WRITE:
            begin
                cls.kind  = KIND_FRAME;
                cls.shift = write_data;
            end
            ACT_READ:  cls.kind = KIND_READ;
            default:   cls.kind = KIND_NONE;
        endcase
    end

    // Queue control
    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign mid_valid = (cnt_reg != '0);
    assign mid_item  = q_reg[rptr_reg];
    assign in_acc    = push && !full;
    assign q_pop     = mid_pop && mid_valid;

    always_comb
    begin
        wptr_next = in_acc ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = q_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + Q_CNT_W'(in_acc) - Q_CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("front queue count overflow");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !q_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("front queue count did not follow accepted item");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        full && !q_pop |=> full)
        else $error("front queue left full without a pop");

endmodule

`default_nettype wire

[rtl/i2cm_back.sv]
// Back end: bus timing engine, delay counter and result queue.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_wdata,
    input  wire i2cm_item_t  mid_item,
    input  wire logic        mid_valid,
    output logic             mid_pop,
    output i2cm_result_t     res_head,
    output logic             res_empty,
    input  wire logic        res_pop
);

    logic [9:0]           tpu_reg;
    i2cm_phase_t          phase_reg, phase_next;
    logic [3:0]           bit_reg, bit_next;
    logic [7:0]           shift_reg, shift_next;
    logic [7:0]           low_reg, low_next;
    logic                 pend_reg, pend_next;
    logic [12:0]          delay_reg, delay_next;
    logic [7:0]           rx_reg, rx_next;
    logic                 ack_reg, ack_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 short_reg, short_next;
    logic                 done_v;

    logic [9:0]           t_eff;
    logic [12:0]          d1, d2, d5, d_half;
    logic                 fire;

    i2cm_result_t         rq_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   rw_ptr_reg, rr_ptr_reg;
    logic [Q_CNT_W-1:0]   rcnt_reg, rcnt_next;
    logic                 r_pop;
    i2cm_result_t         res_in;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TICKS_PER_US_RESET;
        end
        else if (cfg_we)
        begin
            tpu_reg <= cfg_wdata;
        end
    end

    // Delay lengths for 1, 2 and 5 units
    assign t_eff  = (tpu_reg == '0) ? 10'd1 : tpu_reg;
    assign d1     = {3'b000, t_eff};
    assign d2     = {2'b00, t_eff, 1'b0};
    assign d5     = {1'b0, t_eff, 2'b00} + {3'b000, t_eff};
    assign d_half = (short_reg && bit_reg == 4'd7) ? d1 : d2;

    // Engine takes an item when the result queue has room
    assign fire    = mid_valid && (rcnt_reg != Q_CNT_W'(Q_DEPTH));
    assign mid_pop = fire;

    // Engine next state
    always_comb
    begin
        logic [3:0] bi;
        logic [7:0] sh;
        logic       fin;

        bi         = bit_reg + 4'd1;
        sh         = {shift_reg[6:0], 1'b0};
        fin        = 1'b0;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        low_next   = low_reg;
        pend_next  = pend_reg;
        delay_next = delay_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        short_next = short_reg;
        done_v     = 1'b0;

        if (fire)
        begin
            case (mid_item.kind)
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (delay_reg > 13'd1)
                        begin
                            delay_next = delay_reg - 13'd1;
                        end
                        else
                        begin
                            // end of the current wait
                            case (phase_reg)
                                PH_S1:
                                begin
                                    sda_next = 1'b0; phase_next = PH_S2; delay_next = d1;
                                end
                                PH_S2:
                                begin
                                    scl_next = 1'b0; phase_next = PH_S3; delay_next = d1;
                                end
                                PH_T1:
                                begin
                                    scl_next = 1'b1; phase_next = PH_T2; delay_next = d1;
                                end
                                PH_T2:
                                begin
                                    sda_next = 1'b1; phase_next = PH_T3; delay_next = d1;
                                end
                                PH_BSET:
                                begin
                                    scl_next = 1'b1; phase_next = PH_BHIGH; delay_next = d_half;
                                end
                                PH_BHIGH:
                                begin
                                    scl_next = 1'b0; phase_next = PH_BLOW; delay_next = d_half;
                                end
                                PH_BLOW:
                                begin
                                    shift_next = sh;
                                    bit_next   = bi;
                                    if (bi >= 4'd8)
                                    begin
                                        sda_next   = 1'b1;
                                        phase_next = PH_KREL;
                                        delay_next = d1;
                                    end
                                    else
                                    begin
                                        sda_next   = sh[7];
                                        phase_next = PH_BSET;
                                        delay_next = (short_reg && bi == 4'd7) ? d1 : d2;
                                    end
                                end
                                PH_KREL:
                                begin
                                    scl_next = 1'b1; phase_next = PH_KHIGH; delay_next = d1;
                                end
                                PH_KHIGH:
                                begin
                                    // ACK is SDA low
                                    ack_next   = ack_reg & ~mid_item.sda;
                                    phase_next = PH_KHOLD;
                                    delay_next = d1;
                                end
                                PH_KHOLD:
                                begin
                                    scl_next = 1'b0; phase_next = PH_KLOW; delay_next = d2;
                                end
                                PH_KLOW:
                                begin
                                    pend_next = 1'b0;
                                    if (pend_reg && ack_reg)
                                    begin
                                        // second frame of a 10-bit address
                                        shift_next = low_reg;
                                        bit_next   = 4'd0;
                                        short_next = 1'b0;
                                        sda_next   = low_reg[7];
                                        phase_next = PH_BSET;
                                        delay_next = d2;
                                    end
                                    else
                                    begin
                                        fin = 1'b1;
                                    end
                                end
                                PH_RHIGH:
                                begin
                                    rx_next    = {rx_reg[6:0], mid_item.sda};
                                    scl_next   = 1'b0;
                                    phase_next = PH_RLOW;
                                    delay_next = d1;
                                end
                                PH_RLOW:
                                begin
                                    bit_next = bi;
                                    if (bi >= 4'd8)
                                    begin
                                        sda_next   = 1'b1;
                                        phase_next = PH_KREL;
                                    end
                                    else
                                    begin
                                        scl_next   = 1'b1;
                                        phase_next = PH_RHIGH;
                                    end
                                    delay_next = d1;
                                end
                                default: fin = 1'b1;
                            endcase
                            if (fin)
                            begin
                                phase_next = PH_IDLE;
                                delay_next = '0;
                                done_v     = 1'b1;
                            end
                        end
                    end
                end
                KIND_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_S1;
                        delay_next = d5;
                    end
                end
                KIND_STOP:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_T1;
                        delay_next = d1;
                    end
                end
                KIND_FRAME:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        ack_next   = 1'b1;
                        bit_next   = 4'd0;
                        shift_next = mid_item.shift;
                        if (mid_item.pend)
                        begin
                            low_next = mid_item.low_byte;
                        end
                        pend_next  = mid_item.pend;
                        short_next = mid_item.rw_short;
                        sda_next   = mid_item.shift[7];
                        phase_next = PH_BSET;
                        delay_next = d2;
                    end
                end
                KIND_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        ack_next   = 1'b1;
                        bit_next   = 4'd0;
                        rx_next    = '0;
                        pend_next  = 1'b0;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_RHIGH;
                        delay_next = d1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            low_reg   <= '0;
            pend_reg  <= 1'b0;
            delay_reg <= '0;
            rx_reg    <= '0;
            ack_reg   <= 1'b1;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            short_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
            pend_reg  <= pend_next;
            delay_reg <= delay_next;
            rx_reg    <= rx_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            short_reg <= short_next;
        end
    end

    // Result item built from the updated state
    always_comb
    begin
        res_in.scl   = scl_next;
        res_in.sda   = sda_next;
        res_in.busy  = (phase_next != PH_IDLE);
        res_in.done  = done_v;
        res_in.ack   = ack_next;
        res_in.rdata = rx_next;
    end

    // Result queue
    assign res_empty = (rcnt_reg == '0);
    assign res_head  = rq_reg[rr_ptr_reg];
    assign r_pop     = res_pop && !res_empty;
    assign rcnt_next = rcnt_reg + Q_CNT_W'(fire) - Q_CNT_W'(r_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_ptr_reg <= '0;
            rr_ptr_reg <= '0;
            rcnt_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                rw_ptr_reg <= rw_ptr_reg + 1'b1;
            end
            if (r_pop)
            begin
                rr_ptr_reg <= rr_ptr_reg + 1'b1;
            end
            rcnt_reg <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rq_reg[rw_ptr_reg] <= res_in;
        end
    end

    // Checks
    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> delay_reg == '0)
        else $error("delay counter loaded while idle");

    a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mid_item.kind != KIND_TICK && phase_reg != PH_IDLE
        |=> $stable(phase_reg) && $stable(delay_reg))
        else $error("command taken while busy");

    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'd8)
        else $error("bit index out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done_v |-> !res_in.busy && $onehot(phase_reg))
        else $error("finished item still reports busy");

endmodule

`default_nettype wire

[rtl/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: front classifier, engine and result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | push / full        | action, sda_in, address, ten_bit_mode,
//           |                    | read_not_write, write_data
//  result   | pop / empty        | scl_out, sda_out, busy_res, done_res, ack_ok,
//           |                    | read_data
//  config   | cfg_we             | cfg_wdata (ticks_per_us)
//
// One item per clock is sustained while the result side keeps popping; the engine handles each item as it is taken.
// An accepted item is registered in the front queue, then its result in the result queue,
// before it reaches the result ports; one result per item.
// Each side holds four items; a stalled result side fills them, then full rises.
// Reset is asynchronous: queues empty, SCL and SDA released, ticks_per_us 72.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  action,
    input  wire logic        sda_in,
    input  wire logic [9:0]  address,
    input  wire logic        ten_bit_mode,
    input  wire logic        read_not_write,
    input  wire logic [7:0]  write_data,
    output logic             empty,
    input  wire logic        pop,
    output logic             scl_out,
    output logic             sda_out,
    output logic             busy_res,
    output logic             done_res,
    output logic             ack_ok,
    output logic [7:0]       read_data
);

    i2cm_item_t   mid_item;
    logic         mid_valid;
    logic         mid_pop;
    i2cm_result_t res_head;

    // Front: classify and queue
    i2cm_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .sda_in         (sda_in),
        .address        (address),
        .ten_bit_mode   (ten_bit_mode),
        .read_not_write (read_not_write),
        .write_data     (write_data),
        .mid_item       (mid_item),
        .mid_valid      (mid_valid),
        .mid_pop        (mid_pop)
    );

    // Back: bus engine and result queue
    i2cm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mid_item  (mid_item),
        .mid_valid (mid_valid),
        .mid_pop   (mid_pop),
        .res_head  (res_head),
        .res_empty (empty),
        .res_pop   (pop)
    );

    // Result fields
    assign scl_out   = res_head.scl;
    assign sda_out   = res_head.sda;
    assign busy_res  = res_head.busy;
    assign done_res  = res_head.done;
    assign ack_ok    = res_head.ack;
    assign read_data = res_head.rdata;

endmodule

`default_nettype wire

[verif/tb_i2c_master_bit_engine.sv]
// Self-checking testbench for the I2C master bit engine: directed rows, then random bus traffic.
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
    import i2cm_pkg::*;

    // Action codes the engine ignores
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    // Rough number of input items for the whole run
    localparam int ITEMS_GOAL = 1200;

    // Line levels and status right after reset, and right after a stop is taken
    localparam i2cm_result_t RES_IDLE = {1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00};
    localparam i2cm_result_t RES_BUSY = {1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00};

    typedef struct packed {
        logic [2:0] act;
        logic       sda;
        logic [9:0] addr;
        logic       ten;
        logic       rw;
        logic [7:0] wdata;
    } bus_item_t;

    typedef enum logic [1:0] {
        ROW_ITEM = 2'd0,   // send one item
        ROW_RUN  = 2'd1,   // tick with a fixed SDA until the engine is idle
        ROW_CFG  = 2'd2    // write ticks_per_us, value carried in the address field
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        bus_item_t    it;
        logic         chk;
        i2cm_result_t exp;
    } dir_row_t;

    // DUT signals
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [9:0] cfg_wdata = 10'd0;
    logic       push = 1'b0;
    logic [2:0] action = ACT_TICK;
    logic       sda_in = 1'b1;
    logic [9:0] address = 10'd0;
    logic       ten_bit_mode = 1'b0;
    logic       read_not_write = 1'b0;
    logic [7:0] write_data = 8'd0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;

    // Bus engine prediction state
    logic [9:0]   rate = TICKS_PER_US_RESET;
    i2cm_phase_t  eng_ph = PH_IDLE;
    logic [3:0]   bit_no = 4'd0;
    logic [7:0]   tx_byte = 8'd0;
    logic [7:0]   lo_byte = 8'd0;
    logic         frame2_due = 1'b0;
    logic [12:0]  wait_cnt = 13'd0;
    logic [7:0]   rx_byte = 8'd0;
    logic         ack_acc = 1'b1;
    logic         scl_m = 1'b1;
    logic         sda_m = 1'b1;
    logic         short_rw = 1'b0;

    i2cm_result_t line_state_q[$];
    dir_row_t     dir_rows[$];
    logic [9:0]   rand_rates[3] = '{10'd2, 10'd1, 10'd0};

    int n_sent = 0;
    int n_cmd = 0;
    int n_done = 0;
    int n_checked = 0;
    int n_err = 0;
    int burst_left = 0;
    int rx_cyc = 0;

    i2c_master_bit_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .action         (action),
        .sda_in         (sda_in),
        .address        (address),
        .ten_bit_mode   (ten_bit_mode),
        .read_not_write (read_not_write),
        .write_data     (write_data),
        .empty          (empty),
        .pop            (pop),
        .scl_out        (scl_out),
        .sda_out        (sda_out),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .ack_ok         (ack_ok),
        .read_data      (read_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Load a wait of some microsecond units; a zero rate counts as one
    function automatic void enter(input i2cm_phase_t p, input int units);
        int per;
        per = (rate == 10'd0) ? 1 : int'(rate);
        eng_ph = p;
        wait_cnt = 13'(units * per);
    endfunction

    // The R/W bit of a 7-bit address runs on half-length waits
    function automatic int halves();
        return (short_rw && bit_no == 4'd7) ? 1 : 2;
    endfunction

    function automatic void shift_out();
        sda_m = tx_byte[7];
        enter(PH_BSET, halves());
    endfunction

    // End of the current wait; returns 1 when the command has finished
    function automatic logic phase_end(input logic line_sda);
        logic fin;
        fin = 1'b0;
        case (eng_ph)
            PH_S1:    begin sda_m = 1'b0; enter(PH_S2, 1); end
            PH_S2:    begin scl_m = 1'b0; enter(PH_S3, 1); end
            PH_T1:    begin scl_m = 1'b1; enter(PH_T2, 1); end
            PH_T2:    begin sda_m = 1'b1; enter(PH_T3, 1); end
            PH_BSET:  begin scl_m = 1'b1; enter(PH_BHIGH, halves()); end
            PH_BHIGH: begin scl_m = 1'b0; enter(PH_BLOW, halves()); end
            PH_BLOW:
            begin
                tx_byte = {tx_byte[6:0], 1'b0};
                bit_no = bit_no + 4'd1;
                if (bit_no >= 4'd8)
                begin
                    sda_m = 1'b1;
                    enter(PH_KREL, 1);
                end
                else
                    shift_out();
            end
            PH_KREL:  begin scl_m = 1'b1; enter(PH_KHIGH, 1); end
            // ACK is SDA low on the last tick of the high unit
            PH_KHIGH: begin ack_acc = ack_acc & ~line_sda; enter(PH_KHOLD, 1); end
            PH_KHOLD: begin scl_m = 1'b0; enter(PH_KLOW, 2); end
            PH_KLOW:
            begin
                // low byte of a 10-bit address only goes out after an acked first frame
                if (frame2_due && ack_acc)
                begin
                    frame2_due = 1'b0;
                    tx_byte = lo_byte;
                    bit_no = 4'd0;
                    short_rw = 1'b0;
                    shift_out();
                end
                else
                begin
                    frame2_due = 1'b0;
                    fin = 1'b1;
                end
            end
            PH_RHIGH:
            begin
                rx_byte = {rx_byte[6:0], line_sda};
                scl_m = 1'b0;
                enter(PH_RLOW, 1);
            end
            PH_RLOW:
            begin
                bit_no = bit_no + 4'd1;
                if (bit_no >= 4'd8)
                begin
                    sda_m = 1'b1;
                    enter(PH_KREL, 1);
                end
                else
                begin
                    scl_m = 1'b1;
                    enter(PH_RHIGH, 1);
                end
            end
            default: fin = 1'b1;
        endcase
        return fin;
    endfunction

    // Advance the engine by one item and return the levels it shows afterwards
    function automatic i2cm_result_t line_state_after(input bus_item_t it);
        i2cm_result_t r;
        logic         fin;
        fin = 1'b0;
        if (it.act == ACT_TICK)
        begin
            if (eng_ph != PH_IDLE)
            begin
                if (wait_cnt > 13'd1)
                    wait_cnt = wait_cnt - 13'd1;
                else if (phase_end(it.sda))
                begin
                    eng_ph = PH_IDLE;
                    wait_cnt = 13'd0;
                    fin = 1'b1;
                    n_done++;
                end
            end
        end
        else if (eng_ph == PH_IDLE)
        begin
            // commands only start from idle; reserved codes fall through
            case (it.act)
                ACT_START:
                begin
                    sda_m = 1'b1;
                    scl_m = 1'b1;
                    enter(PH_S1, 5);
                end
                ACT_STOP:
                begin
                    sda_m = 1'b0;
                    enter(PH_T1, 1);
                end
                ACT_ADDR:
                begin
                    ack_acc = 1'b1;
                    bit_no = 4'd0;
                    if (it.ten)
                    begin
                        tx_byte = {5'b11110, it.addr[9:8], it.rw};
                        lo_byte = it.addr[7:0];
                        frame2_due = 1'b1;
                        short_rw = 1'b0;
                    end
                    else
                    begin
                        tx_byte = {it.addr[6:0], it.rw};
                        frame2_due = 1'b0;
                        short_rw = 1'b1;
                    end
                    shift_out();
                end
                ACT_WRITE:
                begin
                    ack_acc = 1'b1;
                    bit_no = 4'd0;
                    tx_byte = it.wdata;
                    frame2_due = 1'b0;
                    short_rw = 1'b0;
                    shift_out();
                end
                ACT_READ:
                begin
                    ack_acc = 1'b1;
                    bit_no = 4'd0;
                    rx_byte = 8'd0;
                    frame2_due = 1'b0;
                    sda_m = 1'b1;
                    scl_m = 1'b1;
                    enter(PH_RHIGH, 1);
                end
                default: ;
            endcase
            if (eng_ph != PH_IDLE)
                n_cmd++;
        end
        r.scl = scl_m;
        r.sda = sda_m;
        r.busy = (eng_ph != PH_IDLE);
        r.done = fin;
        r.ack = ack_acc;
        r.rdata = rx_byte;
        return r;
    endfunction

    function automatic bus_item_t rand_item(input logic [2:0] act);
        bus_item_t it;
        it.act = act;
        it.sda = 1'($urandom_range(0, 1));
        it.addr = 10'($urandom_range(0, 1023));
        it.ten = 1'($urandom_range(0, 1));
        it.rw = 1'($urandom_range(0, 1));
        it.wdata = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [2:0] act,
                                    input logic sda, input logic [9:0] addr,
                                    input logic ten, input logic rw, input logic [7:0] wdata,
                                    input logic chk, input i2cm_result_t exp);
        dir_row_t r;
        r.kind = kind;
        r.it.act = act;
        r.it.sda = sda;
        r.it.addr = addr;
        r.it.ten = ten;
        r.it.rw = rw;
        r.it.wdata = wdata;
        r.chk = chk;
        r.exp = exp;
        dir_rows.push_back(r);
    endfunction

    // Send one item in bursts with random gaps; predicts it once accepted
    task automatic send_item(input bus_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push <= 1'b1;
        action <= it.act;
        sda_in <= it.sda;
        address <= it.addr;
        ten_bit_mode <= it.ten;
        read_not_write <= it.rw;
        write_data <= it.wdata;
        @(posedge clk);
        while (full)
            @(posedge clk);
        line_state_q.push_back(line_state_after(it));
        n_sent++;
    endtask

    // Tick until the engine is idle; low_pct is the chance of SDA low on a tick
    task automatic tick_until_idle(input int low_pct, input bit noisy);
        bus_item_t it;
        while (eng_ph != PH_IDLE)
        begin
            if (noisy && $urandom_range(0, 49) == 0)
                it = rand_item(3'($urandom_range(ACT_START, ACT_RSVD7)));
            else
            begin
                it = rand_item(ACT_TICK);
                it.sda = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
            end
            send_item(it);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (line_state_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [9:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate = v;
    endtask

    task automatic do_cmd(input logic [2:0] act, input int low_pct);
        send_item(rand_item(act));
        tick_until_idle(low_pct, 1'b1);
    endtask

    // Well-formed transfer: start, address, some bytes, optional repeated start, stop
    task automatic random_transfer();
        int low_pct;
        int segs;
        int nbytes;
        low_pct = $urandom_range(55, 100);
        segs = $urandom_range(1, 2);
        repeat (segs)
        begin
            do_cmd(ACT_START, low_pct);
            do_cmd(ACT_ADDR, low_pct);
            nbytes = $urandom_range(0, 4);
            repeat (nbytes)
                do_cmd(($urandom_range(0, 1) != 0) ? ACT_WRITE : ACT_READ, low_pct);
        end
        do_cmd(ACT_STOP, low_pct);
    endtask

    // Random codes with ticking cut short, so later commands land while busy
    task automatic broken_sequence();
        int n;
        int cut;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            send_item(rand_item(3'($urandom_range(ACT_TICK, ACT_RSVD7))));
            cut = $urandom_range(0, 40);
            while (cut > 0 && eng_ph != PH_IDLE)
            begin
                send_item(rand_item(ACT_TICK));
                cut--;
            end
        end
    endtask

    function automatic void cmp_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
        if (want !== got)
        begin
            n_err++;
            if (n_err <= 10)
                $display("mismatch in %s at result %0d: expected %0h, got %0h",
                         name, n_checked, want, got);
        end
    endfunction

    // Result side: check accepted results, stall on a rotating pattern
    always @(posedge clk)
    begin : rx_side
        i2cm_result_t want;
        if (rst_n)
        begin
            rx_cyc <= rx_cyc + 1;
            if (pop && !empty)
            begin
                if (line_state_q.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("result with nothing expected at result %0d", n_checked);
                end
                else
                begin
                    want = line_state_q.pop_front();
                    cmp_field("scl_out", 8'(want.scl), 8'(scl_out));
                    cmp_field("sda_out", 8'(want.sda), 8'(sda_out));
                    cmp_field("busy_res", 8'(want.busy), 8'(busy_res));
                    cmp_field("done_res", 8'(want.done), 8'(done_res));
                    cmp_field("ack_ok", 8'(want.ack), 8'(ack_ok));
                    cmp_field("read_data", want.rdata, read_data);
                end
                n_checked++;
            end
            case (rx_cyc[9:8])
                2'd0:    pop <= 1'b1;
                2'd1:    pop <= ($urandom_range(0, 3) != 0);
                2'd2:    pop <= ((rx_cyc % 11) < 4);
                default: pop <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Stimulus
    initial
    begin
        int k;
        int goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle behavior and busy rejection at the reset rate
        add_row(ROW_ITEM, ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b1, RES_IDLE);
        add_row(ROW_ITEM, ACT_TICK,  1'b1, 10'h3FF, 1'b1, 1'b1, 8'hFF, 1'b1, RES_IDLE);
        add_row(ROW_ITEM, ACT_RSVD7, 1'b1, 10'h3FF, 1'b1, 1'b1, 8'hFF, 1'b1, RES_IDLE);
        add_row(ROW_ITEM, ACT_RSVD6, 1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b1, RES_IDLE);
        add_row(ROW_ITEM, ACT_STOP,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b1, RES_BUSY);
        add_row(ROW_ITEM, ACT_READ,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b1, RES_BUSY);
        add_row(ROW_ITEM, ACT_START, 1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b1, RES_BUSY);
        add_row(ROW_RUN,  ACT_TICK,  1'b1, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        // one tick per unit: 7-bit address, bytes with ACK and NACK, reads
        add_row(ROW_CFG,  ACT_TICK,  1'b0, 10'd1,   1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_ADDR,  1'b0, 10'h3FF, 1'b0, 1'b1, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_WRITE, 1'b0, 10'h000, 1'b0, 1'b0, 8'hFF, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b1, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_START, 1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_WRITE, 1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_READ,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b1, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_READ,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        // 10-bit address: both frames acked, then NACK on the first frame
        add_row(ROW_ITEM, ACT_ADDR,  1'b0, 10'h3FF, 1'b1, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_ADDR,  1'b0, 10'h000, 1'b1, 1'b1, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b1, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_STOP,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        // zero rate acts as one tick per unit
        add_row(ROW_CFG,  ACT_TICK,  1'b0, 10'd0,   1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_START, 1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_ITEM, ACT_ADDR,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);
        add_row(ROW_RUN,  ACT_TICK,  1'b0, 10'h000, 1'b0, 1'b0, 8'h00, 1'b0, RES_IDLE);

        for (k = 0; k < dir_rows.size(); k++)
        begin
            case (dir_rows[k].kind)
                ROW_CFG: write_rate(dir_rows[k].it.addr);
                ROW_RUN: tick_until_idle(dir_rows[k].it.sda ? 0 : 100, 1'b0);
                default:
                begin
                    send_item(dir_rows[k].it);
                    if (dir_rows[k].chk)
                        line_state_q[line_state_q.size() - 1] = dir_rows[k].exp;
                end
            endcase
        end

        // random traffic, the remaining item budget split over the rates
        foreach (rand_rates[p])
        begin
            write_rate(rand_rates[p]);
            goal = n_sent + (ITEMS_GOAL - n_sent) / ($size(rand_rates) - p);
            do
            begin
                if ($urandom_range(0, 4) == 0)
                    broken_sequence();
                else
                    random_transfer();
            end
            while (n_sent < goal);
            tick_until_idle(90, 1'b0);
        end

        drain();
        $display("Sent %0d items, %0d bus commands started and %0d finished, %0d results checked.",
                 n_sent, n_cmd, n_done, n_checked);
        $display("Rates 72, 1 and 0 directed, then random transfers at rates 2, 1 and 0.");
        if (n_err == 0 && line_state_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Run did not finish within the time limit.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
